// ----- hw/rtl/cpt_pkg.sv -----
// ============================================================================
// cpt_pkg
// Types, widths and constants shared by the closest point on triangle block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int COORD_FRAC_BITS = 8;

    localparam int PT_W   = 24;
    localparam int VTX_W  = 16;
    localparam int VQ_W   = VTX_W + COORD_FRAC_BITS;
    localparam int PD_W   = ((PT_W > VQ_W) ? PT_W : VQ_W) + 1;
    localparam int DIFF_W = VTX_W + 1;
    localparam int MP_W   = DIFF_W + PD_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DOT_W  = MP_W + 2;
    localparam int DEN_W  = SQ_W;
    localparam int PROD_W = DIFF_W + DOT_W;
    localparam int Q_W    = 41;
    localparam int HI_W   = PROD_W - Q_W;
    localparam int BIG_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int SUM_W  = ((VQ_W > Q_W + 1) ? VQ_W : Q_W + 1) + 2;

    localparam int LANE_LAT   = Q_W + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [Q_W-1:0] Q_LIM = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [PT_W-1:0] OUT_MAX = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] OUT_MIN = {1'b1, {(PT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_VTX_A   = 3'd0,
        REG_VTX_B   = 3'd1,
        REG_VTX_C   = 3'd2,
        REG_EDGE_AB = 3'd3,
        REG_EDGE_BC = 3'd4,
        REG_EDGE_CA = 3'd5,
        REG_INSIDE  = 3'd6
    } t_region;

    typedef struct packed {
        logic signed [PT_W-1:0]  point_x;
        logic signed [PT_W-1:0]  point_y;
        logic signed [VTX_W-1:0] vertex_a_x;
        logic signed [VTX_W-1:0] vertex_a_y;
        logic signed [VTX_W-1:0] vertex_b_x;
        logic signed [VTX_W-1:0] vertex_b_y;
        logic signed [VTX_W-1:0] vertex_c_x;
        logic signed [VTX_W-1:0] vertex_c_y;
    } t_in;

    typedef struct packed {
        logic signed [PT_W-1:0] closest_x;
        logic signed [PT_W-1:0] closest_y;
        t_region                region;
    } t_out;

    typedef struct packed {
        t_region                  region;
        logic signed [VQ_W-1:0]   base_x;
        logic signed [VQ_W-1:0]   base_y;
    } t_side;

    typedef struct packed {
        t_side                    side;
        logic signed [DIFF_W-1:0] sx0;
        logic signed [DIFF_W-1:0] sx1;
        logic signed [DIFF_W-1:0] sy0;
        logic signed [DIFF_W-1:0] sy1;
        logic signed [DOT_W-1:0]  fb;
        logic signed [DOT_W-1:0]  fc;
        logic [DEN_W-1:0]         den;
        logic                     den_neg;
    } t_job;

endpackage

`default_nettype wire

// ----- hw/rtl/cpt_if.sv -----
// ============================================================================
// cpt_if
// Valid/ready channels for query words and result words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface cpt_in_if;
    import cpt_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpt_out_if;
    import cpt_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cpt_front.sv -----
// ============================================================================
// cpt_front
// Three-stage front: differences, products, sums, then region classification
// and setup of the divide job.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cpt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpt_in_if.sink        i_pt,
    input  logic          i_en,
    output logic          o_job_vld,
    output cpt_pkg::t_job o_job
);
    import cpt_pkg::*;

    function automatic logic opp_or_zero(logic signed [DOT_W-1:0] a,
                                         logic signed [DOT_W-1:0] b);
        return (a == 0) || (b == 0) || (a[DOT_W-1] != b[DOT_W-1]);
    endfunction

    function automatic logic le0(logic signed [DOT_W-1:0] a);
        return a[DOT_W-1] || (a == 0);
    endfunction

    logic signed [VQ_W-1:0]   n_aqx, n_aqy, n_bqx, n_bqy, n_cqx, n_cqy;

    // stage 1
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_abx, r1_aby, r1_acx, r1_acy, r1_bcx, r1_bcy;
    logic signed [PD_W-1:0]   r1_apx, r1_apy, r1_bpx, r1_bpy, r1_cpx, r1_cpy;
    logic signed [VQ_W-1:0]   r1_aqx, r1_aqy, r1_bqx, r1_bqy, r1_cqx, r1_cqy;

    // stage 2
    logic                     r2_vld;
    logic signed [MP_W-1:0]   r2_d1a, r2_d1b, r2_d2a, r2_d2b, r2_d3a, r2_d3b;
    logic signed [MP_W-1:0]   r2_d4a, r2_d4b, r2_d5a, r2_d5b, r2_d6a, r2_d6b;
    logic signed [MP_W-1:0]   r2_wca, r2_wcb, r2_wba, r2_wbb, r2_vaa, r2_vab;
    logic signed [SQ_W-1:0]   r2_na, r2_nb, r2_abxx, r2_abyy, r2_acxx, r2_acyy;
    logic signed [SQ_W-1:0]   r2_bcxx, r2_bcyy;
    logic signed [DIFF_W-1:0] r2_abx, r2_aby, r2_acx, r2_acy, r2_bcx, r2_bcy;
    logic signed [VQ_W-1:0]   r2_aqx, r2_aqy, r2_bqx, r2_bqy, r2_cqx, r2_cqy;

    // stage 3
    logic                     r3_vld;
    logic signed [DOT_W-1:0]  r3_d1, r3_d2, r3_d3, r3_d4, r3_d5, r3_d6;
    logic signed [DOT_W-1:0]  r3_e1, r3_e2, r3_wb, r3_wc, r3_va, r3_n;
    logic [DEN_W-1:0]         r3_den_ab, r3_den_ac, r3_den_bc;
    logic signed [DIFF_W-1:0] r3_abx, r3_aby, r3_acx, r3_acy, r3_bcx, r3_bcy;
    logic signed [VQ_W-1:0]   r3_aqx, r3_aqy, r3_bqx, r3_bqy, r3_cqx, r3_cqy;

    logic signed [DOT_W-1:0]  n_nabs;

    assign i_pt.ready = i_en;

    assign n_aqx = {i_pt.data.vertex_a_x, {COORD_FRAC_BITS{1'b0}}};
    assign n_aqy = {i_pt.data.vertex_a_y, {COORD_FRAC_BITS{1'b0}}};
    assign n_bqx = {i_pt.data.vertex_b_x, {COORD_FRAC_BITS{1'b0}}};
    assign n_bqy = {i_pt.data.vertex_b_y, {COORD_FRAC_BITS{1'b0}}};
    assign n_cqx = {i_pt.data.vertex_c_x, {COORD_FRAC_BITS{1'b0}}};
    assign n_cqy = {i_pt.data.vertex_c_y, {COORD_FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_pt.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_abx <= DIFF_W'(i_pt.data.vertex_b_x) - DIFF_W'(i_pt.data.vertex_a_x);
            r1_aby <= DIFF_W'(i_pt.data.vertex_b_y) - DIFF_W'(i_pt.data.vertex_a_y);
            r1_acx <= DIFF_W'(i_pt.data.vertex_c_x) - DIFF_W'(i_pt.data.vertex_a_x);
            r1_acy <= DIFF_W'(i_pt.data.vertex_c_y) - DIFF_W'(i_pt.data.vertex_a_y);
            r1_bcx <= DIFF_W'(i_pt.data.vertex_c_x) - DIFF_W'(i_pt.data.vertex_b_x);
            r1_bcy <= DIFF_W'(i_pt.data.vertex_c_y) - DIFF_W'(i_pt.data.vertex_b_y);
            r1_apx <= PD_W'(i_pt.data.point_x) - PD_W'(n_aqx);
            r1_apy <= PD_W'(i_pt.data.point_y) - PD_W'(n_aqy);
            r1_bpx <= PD_W'(i_pt.data.point_x) - PD_W'(n_bqx);
            r1_bpy <= PD_W'(i_pt.data.point_y) - PD_W'(n_bqy);
            r1_cpx <= PD_W'(i_pt.data.point_x) - PD_W'(n_cqx);
            r1_cpy <= PD_W'(i_pt.data.point_y) - PD_W'(n_cqy);
            r1_aqx <= n_aqx;
            r1_aqy <= n_aqy;
            r1_bqx <= n_bqx;
            r1_bqy <= n_bqy;
            r1_cqx <= n_cqx;
            r1_cqy <= n_cqy;

            r2_d1a  <= r1_abx * r1_apx;
            r2_d1b  <= r1_aby * r1_apy;
            r2_d2a  <= r1_acx * r1_apx;
            r2_d2b  <= r1_acy * r1_apy;
            r2_d3a  <= r1_abx * r1_bpx;
            r2_d3b  <= r1_aby * r1_bpy;
            r2_d4a  <= r1_acx * r1_bpx;
            r2_d4b  <= r1_acy * r1_bpy;
            r2_d5a  <= r1_abx * r1_cpx;
            r2_d5b  <= r1_aby * r1_cpy;
            r2_d6a  <= r1_acx * r1_cpx;
            r2_d6b  <= r1_acy * r1_cpy;
            r2_wca  <= r1_abx * r1_apy;
            r2_wcb  <= r1_aby * r1_apx;
            r2_wba  <= r1_acy * r1_apx;
            r2_wbb  <= r1_acx * r1_apy;
            r2_vaa  <= r1_bcx * r1_bpy;
            r2_vab  <= r1_bcy * r1_bpx;
            r2_na   <= r1_abx * r1_acy;
            r2_nb   <= r1_aby * r1_acx;
            r2_abxx <= r1_abx * r1_abx;
            r2_abyy <= r1_aby * r1_aby;
            r2_acxx <= r1_acx * r1_acx;
            r2_acyy <= r1_acy * r1_acy;
            r2_bcxx <= r1_bcx * r1_bcx;
            r2_bcyy <= r1_bcy * r1_bcy;
            r2_abx  <= r1_abx;
            r2_aby  <= r1_aby;
            r2_acx  <= r1_acx;
            r2_acy  <= r1_acy;
            r2_bcx  <= r1_bcx;
            r2_bcy  <= r1_bcy;
            r2_aqx  <= r1_aqx;
            r2_aqy  <= r1_aqy;
            r2_bqx  <= r1_bqx;
            r2_bqy  <= r1_bqy;
            r2_cqx  <= r1_cqx;
            r2_cqy  <= r1_cqy;

            r3_d1 <= DOT_W'(r2_d1a) + DOT_W'(r2_d1b);
            r3_d2 <= DOT_W'(r2_d2a) + DOT_W'(r2_d2b);
            r3_d3 <= DOT_W'(r2_d3a) + DOT_W'(r2_d3b);
            r3_d4 <= DOT_W'(r2_d4a) + DOT_W'(r2_d4b);
            r3_d5 <= DOT_W'(r2_d5a) + DOT_W'(r2_d5b);
            r3_d6 <= DOT_W'(r2_d6a) + DOT_W'(r2_d6b);
            r3_e1 <= (DOT_W'(r2_d4a) + DOT_W'(r2_d4b)) - (DOT_W'(r2_d3a) + DOT_W'(r2_d3b));
            r3_e2 <= (DOT_W'(r2_d5a) + DOT_W'(r2_d5b)) - (DOT_W'(r2_d6a) + DOT_W'(r2_d6b));
            r3_wc <= DOT_W'(r2_wca) - DOT_W'(r2_wcb);
            r3_wb <= DOT_W'(r2_wba) - DOT_W'(r2_wbb);
            r3_va <= DOT_W'(r2_vaa) - DOT_W'(r2_vab);
            r3_n  <= DOT_W'(r2_na) - DOT_W'(r2_nb);
            r3_den_ab <= DEN_W'(unsigned'(r2_abxx)) + DEN_W'(unsigned'(r2_abyy));
            r3_den_ac <= DEN_W'(unsigned'(r2_acxx)) + DEN_W'(unsigned'(r2_acyy));
            r3_den_bc <= DEN_W'(unsigned'(r2_bcxx)) + DEN_W'(unsigned'(r2_bcyy));
            r3_abx <= r2_abx;
            r3_aby <= r2_aby;
            r3_acx <= r2_acx;
            r3_acy <= r2_acy;
            r3_bcx <= r2_bcx;
            r3_bcy <= r2_bcy;
            r3_aqx <= r2_aqx;
            r3_aqy <= r2_aqy;
            r3_bqx <= r2_bqx;
            r3_bqy <= r2_bqy;
            r3_cqx <= r2_cqx;
            r3_cqy <= r2_cqy;
        end
    end

    assign n_nabs = r3_n[DOT_W-1] ? -r3_n : r3_n;

    // region tests in priority order; unused lanes get zero factors, and jobs with no division get a unit divisor
    always_comb begin
        o_job             = '0;
        o_job.side.region = REG_INSIDE;
        o_job.side.base_x = r3_aqx;
        o_job.side.base_y = r3_aqy;
        o_job.den         = DEN_W'(1);
        priority if (le0(r3_d1) && le0(r3_d2)) begin
            o_job.side.region = REG_VTX_A;
        end else if (!r3_d3[DOT_W-1] && (r3_d4 <= r3_d3)) begin
            o_job.side.region = REG_VTX_B;
            o_job.side.base_x = r3_bqx;
            o_job.side.base_y = r3_bqy;
        end else if (opp_or_zero(r3_n, r3_wc) && !r3_d1[DOT_W-1] && le0(r3_d3)) begin
            o_job.side.region = REG_EDGE_AB;
            if (r3_den_ab != '0) begin
                o_job.sx0 = r3_abx;
                o_job.sy0 = r3_aby;
                o_job.fb  = r3_d1;
                o_job.den = r3_den_ab;
            end
        end else if (!r3_d6[DOT_W-1] && (r3_d5 <= r3_d6)) begin
            o_job.side.region = REG_VTX_C;
            o_job.side.base_x = r3_cqx;
            o_job.side.base_y = r3_cqy;
        end else if (opp_or_zero(r3_n, r3_wb) && !r3_d2[DOT_W-1] && le0(r3_d6)) begin
            o_job.side.region = REG_EDGE_CA;
            if (r3_den_ac != '0) begin
                o_job.sx0 = r3_acx;
                o_job.sy0 = r3_acy;
                o_job.fb  = r3_d2;
                o_job.den = r3_den_ac;
            end
        end else if (opp_or_zero(r3_n, r3_va) && !r3_e1[DOT_W-1] && !r3_e2[DOT_W-1]) begin
            o_job.side.region = REG_EDGE_BC;
            o_job.side.base_x = r3_bqx;
            o_job.side.base_y = r3_bqy;
            if (r3_den_bc != '0) begin
                o_job.sx0 = r3_bcx;
                o_job.sy0 = r3_bcy;
                o_job.fb  = r3_e1;
                o_job.den = r3_den_bc;
            end
        end else begin
            if (r3_n != 0) begin
                o_job.sx0     = r3_abx;
                o_job.sx1     = r3_acx;
                o_job.sy0     = r3_aby;
                o_job.sy1     = r3_acy;
                o_job.fb      = r3_wb;
                o_job.fc      = r3_wc;
                o_job.den     = n_nabs[DEN_W-1:0];
                o_job.den_neg = r3_n[DOT_W-1];
            end
        end
    end

    assign o_job_vld = r3_vld;

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_fifo.sv -----
// ============================================================================
// cpt_fifo
// Short job queue between classifier front and divider back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cpt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpt_pkg::t_job i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output cpt_pkg::t_job o_rdata
);
    import cpt_pkg::*;

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_div_lane.sv -----
// ============================================================================
// cpt_div_lane
// One muldiv lane: product, then pipelined restoring division, one quotient
// bit per stage, quotient saturated and signed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cpt_div_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [cpt_pkg::DIFF_W-1:0] i_small,
    input  logic signed [cpt_pkg::DOT_W-1:0]  i_big,
    input  logic [cpt_pkg::DEN_W-1:0]         i_den,
    input  logic                              i_den_neg,
    output logic signed [cpt_pkg::Q_W:0]      o_q
);
    import cpt_pkg::*;

    logic signed [PROD_W-1:0] r_p;
    logic [DEN_W-1:0]         r_pden;
    logic                     r_pdneg;

    logic [PROD_W-1:0]        n_mag;
    logic [BIG_W-1:0]         n_hi;

    logic [PROD_W-1:0]        r_mag [0:Q_W];
    logic [DEN_W-1:0]         r_rem [0:Q_W];
    logic [DEN_W-1:0]         r_den [0:Q_W];
    logic [Q_W-1:0]           r_q   [0:Q_W];
    logic                     r_big [0:Q_W];
    logic                     r_neg [0:Q_W];

    logic [DEN_W:0]           n_try [1:Q_W];
    logic [DEN_W:0]           n_sub [1:Q_W];
    logic                     n_ge  [1:Q_W];

    logic [Q_W-1:0]           n_qsat;

    assign n_mag = r_p[PROD_W-1] ? unsigned'(-r_p) : unsigned'(r_p);
    assign n_hi  = BIG_W'(n_mag[PROD_W-1:Q_W]);

    always_comb begin
        for (int k = 1; k <= Q_W; k++) begin
            n_try[k] = {r_rem[k-1], r_mag[k-1][Q_W-k]};
            n_sub[k] = n_try[k] - {1'b0, r_den[k-1]};
            n_ge[k]  = (n_try[k] >= {1'b0, r_den[k-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= i_small * i_big;
            r_pden  <= i_den;
            r_pdneg <= i_den_neg;

            // quotient of 2^Q_W or more is flagged here; any quotient above 2^(Q_W-1) saturates
            r_mag[0] <= n_mag;
            r_rem[0] <= n_hi[DEN_W-1:0];
            r_den[0] <= r_pden;
            r_q[0]   <= '0;
            r_big[0] <= (n_hi >= BIG_W'(r_pden));
            r_neg[0] <= r_p[PROD_W-1] ^ r_pdneg;

            for (int k = 1; k <= Q_W; k++) begin
                r_mag[k] <= r_mag[k-1];
                r_rem[k] <= n_ge[k] ? n_sub[k][DEN_W-1:0] : n_try[k][DEN_W-1:0];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][Q_W-2:0], n_ge[k]};
                r_big[k] <= r_big[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign n_qsat = (r_big[Q_W] || (r_q[Q_W] > Q_LIM)) ? Q_LIM : r_q[Q_W];
    assign o_q    = r_neg[Q_W] ? -signed'({1'b0, n_qsat}) : signed'({1'b0, n_qsat});

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_back.sv -----
// ============================================================================
// cpt_back
// Four muldiv lanes, sideband delay line, final sum, clamp and output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cpt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_vld,
    input  cpt_pkg::t_job i_job,
    output logic          o_pop,
    cpt_out_if.source     o_cp
);
    import cpt_pkg::*;

    function automatic logic signed [PT_W-1:0] clamp(logic signed [SUM_W-1:0] v);
        logic signed [PT_W-1:0] res;
        if (v > SUM_W'(OUT_MAX)) begin
            res = OUT_MAX;
        end else if (v < SUM_W'(OUT_MIN)) begin
            res = OUT_MIN;
        end else begin
            res = v[PT_W-1:0];
        end
        return res;
    endfunction

    logic                   n_en;
    logic                   r_svld [0:LANE_LAT-1];
    t_side                  r_side [0:LANE_LAT-1];
    logic signed [Q_W:0]    n_qx0, n_qx1, n_qy0, n_qy1;
    logic signed [SUM_W-1:0] n_sx, n_sy;
    logic                   r_ovld;
    t_out                   r_out;

    assign n_en  = !r_ovld || o_cp.ready;
    assign o_pop = n_en && i_job_vld;

    cpt_div_lane u_lane_x0 (
        .i_clk(i_clk), .i_en(n_en), .i_small(i_job.sx0), .i_big(i_job.fb),
        .i_den(i_job.den), .i_den_neg(i_job.den_neg), .o_q(n_qx0)
    );
    cpt_div_lane u_lane_x1 (
        .i_clk(i_clk), .i_en(n_en), .i_small(i_job.sx1), .i_big(i_job.fc),
        .i_den(i_job.den), .i_den_neg(i_job.den_neg), .o_q(n_qx1)
    );
    cpt_div_lane u_lane_y0 (
        .i_clk(i_clk), .i_en(n_en), .i_small(i_job.sy0), .i_big(i_job.fb),
        .i_den(i_job.den), .i_den_neg(i_job.den_neg), .o_q(n_qy0)
    );
    cpt_div_lane u_lane_y1 (
        .i_clk(i_clk), .i_en(n_en), .i_small(i_job.sy1), .i_big(i_job.fc),
        .i_den(i_job.den), .i_den_neg(i_job.den_neg), .o_q(n_qy1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_svld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (n_en) begin
            r_svld[0] <= i_job_vld;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_svld[k] <= r_svld[k-1];
            end
            r_ovld <= r_svld[LANE_LAT-1];
        end
    end

    assign n_sx = SUM_W'(r_side[LANE_LAT-1].base_x) + SUM_W'(n_qx0) + SUM_W'(n_qx1);
    assign n_sy = SUM_W'(r_side[LANE_LAT-1].base_y) + SUM_W'(n_qy0) + SUM_W'(n_qy1);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side[0] <= i_job.side;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out.closest_x <= clamp(n_sx);
            r_out.closest_y <= clamp(n_sy);
            r_out.region    <= r_side[LANE_LAT-1].region;
        end
    end

    assign o_cp.valid = r_ovld;
    assign o_cp.data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/closest_point_on_triangle.sv -----
// ============================================================================
// closest_point_on_triangle
// Closest point of a 2D triangle to a fixed-point query point, with region.
// ============================================================================
//  channel  dir  modport  word
//  i_pt     in   sink     query point and three vertices (t_in)
//  o_cp     out  source   closest point and region code (t_out)
//
//  One word in and one word out per cycle, sustained while o_cp is ready.
//  Pipeline: 3 front stages, the queue, 43 divider stages (product, setup,
//  then one quotient bit per stage) and the output register.
//  Synchronous active-low reset clears valid bits, queue pointers and queue count only.
//  An output stall freezes the back end; the 4-deep queue absorbs the front until it fills.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_triangle (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpt_in_if.sink     i_pt,
    cpt_out_if.source  o_cp
);
    import cpt_pkg::*;

    logic  n_front_vld;
    t_job  n_front_job;
    logic  n_full;
    logic  n_pop;
    logic  n_q_vld;
    t_job  n_q_job;

    cpt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pt      (i_pt),
        .i_en      (!n_full),
        .o_job_vld (n_front_vld),
        .o_job     (n_front_job)
    );

    cpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_front_vld && !n_full),
        .i_wdata (n_front_job),
        .o_full  (n_full),
        .i_pop   (n_pop),
        .o_vld   (n_q_vld),
        .o_rdata (n_q_job)
    );

    cpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (n_q_vld),
        .i_job     (n_q_job),
        .o_pop     (n_pop),
        .o_cp      (o_cp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_checker.sv -----
// ============================================================================
// cpt_checker
// Port-level checks on the closest point block, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cpt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  cpt_pkg::t_out i_out_data
);
    import cpt_pkg::*;

    localparam logic signed [PT_W-1:0] FRAC_MASK = PT_W'((1 << COORD_FRAC_BITS) - 1);

    // vertex results sit on whole pixels
    a_vertex_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.region == REG_VTX_A || i_out_data.region == REG_VTX_B
                        || i_out_data.region == REG_VTX_C)
        |-> ((i_out_data.closest_x & FRAC_MASK) == 0)
            && ((i_out_data.closest_y & FRAC_MASK) == 0))
        else $error("vertex result off the pixel grid");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("input not ready right after reset");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_ready))
        else $error("input ready unknown");

endmodule

bind closest_point_on_triangle cpt_checker u_cpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_cp.valid),
    .i_out_ready (o_cp.ready),
    .i_out_data  (o_cp.data)
);

`default_nettype wire
